// ----- hw/rtl/vna_pkg.sv -----
`default_nettype none
package vna_pkg;

  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int NRM_W = 16;
  localparam int SUM_W = 20;
  localparam int DIF_W = 17;
  localparam int PRD_W = 34;
  localparam int CRS_W = 35;
  localparam int UZ_W  = 41;
  localparam int LEN_W = 62;
  localparam int SQ_W  = 60;
  localparam int MAG_W = 30;
  localparam int RT_W  = 31;
  localparam int QT_W  = 15;

  localparam logic [QT_W-1:0] ONE_Q14 = 15'd16384;
  localparam logic [SUM_W-1:0] SUM_MAX = 20'h7FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 20'h80000;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef logic signed [UZ_W-1:0] uz_vec_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    logic start;
    logic invert;
  } uz_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } uz_sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TP0,
    ST_TP1,
    ST_TP2,
    ST_XPRD,
    ST_TNRM,
    ST_ARD,
    ST_AWR,
    ST_RWAIT,
    ST_RNRM,
    ST_ROUT
  } vna_state_t;

  typedef enum logic [2:0] {
    UZ_IDLE,
    UZ_NORM,
    UZ_SQ,
    UZ_SQRT,
    UZ_DINIT,
    UZ_DSTEP,
    UZ_DEND,
    UZ_FIN
  } uz_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vna_if.sv -----
`default_nettype none
interface vna_in_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic [IDX_W-1:0]        index_c;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, kind, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, kind, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vna_out_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;

  modport source (output valid, vertex_index, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, vertex_index, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/vna_unitize.sv -----
`default_nettype none
module vna_unitize import vna_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  uz_ctl_t ctl,
  input  uz_vec_t vin [3],
  output uz_sts_t sts,
  output nrm_t    vout [3]
);

  uz_state_t        st_r, st_nxt;
  logic             inv_r;
  logic             neg_r [3];
  logic [UZ_W-1:0]  m_r [3];
  logic [4:0]       cnt_r;
  logic [1:0]       k_r;
  logic [SQ_W-1:0]  prd_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] x_r;
  logic [LEN_W-1:0] res_r;
  logic [LEN_W-1:0] bit_r;
  logic [RT_W-1:0]  rem_r;
  logic [QT_W-1:0]  nsh_r;
  logic [QT_W-1:0]  q_r;
  nrm_t             o_r [3];

  logic             any_hi, any_29, all_zero;
  logic [MAG_W-1:0] sq_sel, dv_sel;
  logic [LEN_W-1:0] sq_try;
  logic [44:0]      num;
  logic [RT_W:0]    dv_try;
  logic             dv_ge;
  logic [RT_W-1:0]  root;
  logic [QT_W-1:0]  q_cap;
  nrm_t             q_ext;
  logic             q_neg;

  always_comb begin
    any_hi   = (|m_r[0][UZ_W-1:MAG_W]) | (|m_r[1][UZ_W-1:MAG_W]) | (|m_r[2][UZ_W-1:MAG_W]);
    any_29   = m_r[0][MAG_W-1] | m_r[1][MAG_W-1] | m_r[2][MAG_W-1];
    all_zero = ~|(m_r[0] | m_r[1] | m_r[2]);
    case (cnt_r[1:0])
      2'd0:    sq_sel = m_r[0][MAG_W-1:0];
      2'd1:    sq_sel = m_r[1][MAG_W-1:0];
      default: sq_sel = m_r[2][MAG_W-1:0];
    endcase
    case (k_r)
      2'd0:    dv_sel = m_r[0][MAG_W-1:0];
      2'd1:    dv_sel = m_r[1][MAG_W-1:0];
      default: dv_sel = m_r[2][MAG_W-1:0];
    endcase
    sq_try = res_r + bit_r;
    root   = res_r[RT_W-1:0];
    num    = {1'b0, dv_sel, 14'b0} + {15'b0, root[RT_W-1:1]};
    dv_try = {rem_r, nsh_r[QT_W-1]};
    dv_ge  = dv_try >= {1'b0, root};
    q_cap  = (q_r > ONE_Q14) ? ONE_Q14 : q_r;
    q_ext  = nrm_t'({1'b0, q_cap});
    case (k_r)
      2'd0:    q_neg = neg_r[0] != inv_r;
      2'd1:    q_neg = neg_r[1] != inv_r;
      default: q_neg = neg_r[2] != inv_r;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      UZ_IDLE:  if (ctl.start) st_nxt = UZ_NORM;
      UZ_NORM: begin
        if (all_zero) st_nxt = UZ_FIN;
        else if (!any_hi && any_29) st_nxt = UZ_SQ;
      end
      UZ_SQ:    if (cnt_r == 5'd4) st_nxt = UZ_SQRT;
      UZ_SQRT:  if (cnt_r == 5'd30) st_nxt = UZ_DINIT;
      UZ_DINIT: st_nxt = UZ_DSTEP;
      UZ_DSTEP: if (cnt_r == 5'd14) st_nxt = UZ_DEND;
      UZ_DEND:  st_nxt = (k_r == 2'd2) ? UZ_FIN : UZ_DINIT;
      UZ_FIN:   st_nxt = UZ_IDLE;
      default:  st_nxt = UZ_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = st_r != UZ_IDLE;
    sts.done = st_r == UZ_FIN;
    for (int i = 0; i < 3; i++) vout[i] = o_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= UZ_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      UZ_IDLE: begin
        if (ctl.start) begin
          inv_r <= ctl.invert;
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vin[i][UZ_W-1];
            m_r[i]   <= vin[i][UZ_W-1] ? (~vin[i] + 1'b1) : vin[i];
          end
        end
      end
      UZ_NORM: begin
        cnt_r <= '0;
        len_r <= '0;
        if (all_zero) begin
          for (int i = 0; i < 3; i++) o_r[i] <= '0;
        end else if (any_hi) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else if (!any_29) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        end
      end
      UZ_SQ: begin
        if (cnt_r < 5'd3) prd_r <= sq_sel * sq_sel;
        if (cnt_r != 5'd0) len_r <= len_r + {2'b0, prd_r};
        if (cnt_r == 5'd4) begin
          x_r   <= len_r;
          res_r <= '0;
          bit_r <= LEN_W'(1) << 60;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      UZ_SQRT: begin
        if (x_r >= sq_try) begin
          x_r   <= x_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        k_r   <= '0;
      end
      UZ_DINIT: begin
        rem_r <= {1'b0, num[44:15]};
        nsh_r <= num[14:0];
        q_r   <= '0;
        cnt_r <= '0;
      end
      UZ_DSTEP: begin
        rem_r <= dv_ge ? RT_W'(dv_try - {1'b0, root}) : dv_try[RT_W-1:0];
        nsh_r <= nsh_r << 1;
        q_r   <= {q_r[QT_W-2:0], dv_ge};
        cnt_r <= cnt_r + 5'd1;
      end
      UZ_DEND: begin
        case (k_r)
          2'd0:    o_r[0] <= q_neg ? -q_ext : q_ext;
          2'd1:    o_r[1] <= q_neg ? -q_ext : q_ext;
          default: o_r[2] <= q_neg ? -q_ext : q_ext;
        endcase
        k_r <= k_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vertex_normal_accumulator.sv -----
`default_nettype none
// Vertex normal accumulator. Load requests are written straight from the idle
// state. A triangle request reads its three corner positions one after another,
// forms the cross product with one 17x17 multiplier, normalizes it in the shared
// unitize unit, then read-modify-writes the three corner sums, one read and one
// write each; a read request goes straight to the unitize unit and then the output
// register. The unitize unit sets the rate: it normalizes, sums the squares, takes
// a bit-pair square root, runs three restoring divides and a finish step (a zero
// vector goes straight to the finish), and the block takes no new request until a
// triangle or read is through, a read including any output stall. After reset
// the block sweeps the normal sums to zero, one entry a cycle, before it takes its
// first request. Indexes at or above VERTEX_COUNT and kind 3 are dropped.
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  vna_in_if.sink     in_ch,
  vna_out_if.source  out_ch
);

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int CW = 17;
  localparam logic [CW-1:0] VC_C = CW'(VERTEX_COUNT);
  localparam logic [AW-1:0] LAST = AW'(VERTEX_COUNT - 1);

  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [3*POS_W-1:0] pos_rd_r;
  logic [3*SUM_W-1:0] sum_rd_r;

  vna_state_t state_r, state_nxt;
  logic [AW-1:0]            clr_r;
  logic [AW-1:0]            ta_r, tb_r, tc_r;
  logic [IDX_W-1:0]         vidx_r;
  logic [3*POS_W-1:0]       p0_r, p1_r;
  logic signed [DIF_W-1:0]  da_r [3];
  logic signed [DIF_W-1:0]  db_r [3];
  logic [2:0]               j_r;
  logic signed [PRD_W-1:0]  prd_r;
  logic signed [CRS_W-1:0]  crs_r [3];
  logic [1:0]               corner_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  nrm_t                     out_n_r [3];

  logic [CW-1:0] ia_ext, ib_ext, ic_ext;
  logic          ok_a, ok_all, in_fire;
  logic [AW-1:0] addr_a, addr_b, addr_c, corner_addr;

  logic               pos_we, pos_re, sum_we, sum_re, out_load;
  logic [AW-1:0]      pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [3*POS_W-1:0] pos_wdata;
  logic [3*SUM_W-1:0] sum_wdata;
  logic [3*SUM_W-1:0] sum_sat;

  uz_ctl_t uz_ctl;
  uz_sts_t uz_sts;
  uz_vec_t uz_vin [3];
  nrm_t    uz_vout [3];

  logic signed [DIF_W-1:0] op_a, op_b;
  logic                    op_sub;
  logic [1:0]              cidx;
  logic signed [CRS_W-1:0] prd_ext;

  vna_unitize u_unitize (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (uz_ctl),
    .vin  (uz_vin),
    .sts  (uz_sts),
    .vout (uz_vout)
  );

  always_comb begin
    ia_ext  = {{(CW-IDX_W){1'b0}}, in_ch.index_a};
    ib_ext  = {{(CW-IDX_W){1'b0}}, in_ch.index_b};
    ic_ext  = {{(CW-IDX_W){1'b0}}, in_ch.index_c};
    ok_a    = ia_ext < VC_C;
    ok_all  = ok_a && (ib_ext < VC_C) && (ic_ext < VC_C);
    addr_a  = ia_ext[AW-1:0];
    addr_b  = ib_ext[AW-1:0];
    addr_c  = ic_ext[AW-1:0];
    in_fire = in_ch.valid && in_ch.ready;
    case (corner_r)
      2'd0:    corner_addr = ta_r;
      2'd1:    corner_addr = tb_r;
      default: corner_addr = tc_r;
    endcase
  end

  // cross product terms in order: +a1b2 -a2b1 +a2b0 -a0b2 +a0b1 -a1b0
  always_comb begin
    case (j_r)
      3'd0:    begin op_a = da_r[1]; op_b = db_r[2]; end
      3'd1:    begin op_a = da_r[2]; op_b = db_r[1]; end
      3'd2:    begin op_a = da_r[2]; op_b = db_r[0]; end
      3'd3:    begin op_a = da_r[0]; op_b = db_r[2]; end
      3'd4:    begin op_a = da_r[0]; op_b = db_r[1]; end
      default: begin op_a = da_r[1]; op_b = db_r[0]; end
    endcase
    op_sub  = ~j_r[0];
    cidx    = 2'((j_r - 3'd1) >> 1);
    prd_ext = {prd_r[PRD_W-1], prd_r};
  end

  always_comb begin
    logic signed [SUM_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {sum_rd_r[i*SUM_W+SUM_W-1], sum_rd_r[i*SUM_W +: SUM_W]}
        + {{(SUM_W+1-NRM_W){uz_vout[i][NRM_W-1]}}, uz_vout[i]};
      if (s[SUM_W] != s[SUM_W-1]) sum_sat[i*SUM_W +: SUM_W] = s[SUM_W] ? SUM_MIN : SUM_MAX;
      else                        sum_sat[i*SUM_W +: SUM_W] = s[SUM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_r == ST_RWAIT)
        uz_vin[i] = {{(UZ_W-SUM_W){sum_rd_r[i*SUM_W+SUM_W-1]}}, sum_rd_r[i*SUM_W +: SUM_W]};
      else
        uz_vin[i] = {{(UZ_W-CRS_W){crs_r[i][CRS_W-1]}}, crs_r[i]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_TRI && ok_all) state_nxt = ST_TP0;
          else if (in_ch.kind == KIND_READ && ok_a) state_nxt = ST_RWAIT;
        end
      end
      ST_TP0:   state_nxt = ST_TP1;
      ST_TP1:   state_nxt = ST_TP2;
      ST_TP2:   state_nxt = ST_XPRD;
      ST_XPRD:  if (j_r == 3'd7) state_nxt = ST_TNRM;
      ST_TNRM:  if (uz_sts.done) state_nxt = ST_ARD;
      ST_ARD:   state_nxt = ST_AWR;
      ST_AWR:   if (corner_r == 2'd2) state_nxt = ST_IDLE; else state_nxt = ST_ARD;
      ST_RWAIT: state_nxt = ST_RNRM;
      ST_RNRM:  if (uz_sts.done) state_nxt = ST_ROUT;
      ST_ROUT:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    pos_we        = 1'b0;
    pos_waddr     = addr_a;
    pos_wdata     = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    pos_re        = 1'b0;
    pos_raddr     = addr_a;
    sum_we        = 1'b0;
    sum_waddr     = addr_a;
    sum_wdata     = '0;
    sum_re        = 1'b0;
    sum_raddr     = addr_a;
    uz_ctl.start  = 1'b0;
    uz_ctl.invert = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_r;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) begin
          if (in_ch.kind == KIND_LOAD && ok_a) begin
            pos_we = 1'b1;
            sum_we = 1'b1;
          end
          if (in_ch.kind == KIND_TRI && ok_all) pos_re = 1'b1;
          if (in_ch.kind == KIND_READ && ok_a) sum_re = 1'b1;
        end
      end
      ST_TP0: begin
        pos_re    = 1'b1;
        pos_raddr = tb_r;
      end
      ST_TP1: begin
        pos_re    = 1'b1;
        pos_raddr = tc_r;
      end
      ST_XPRD: begin
        uz_ctl.start  = j_r == 3'd7;
        uz_ctl.invert = 1'b1;
      end
      ST_ARD: begin
        sum_re    = 1'b1;
        sum_raddr = corner_addr;
      end
      ST_AWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_addr;
        sum_wdata = sum_sat;
      end
      ST_RWAIT: uz_ctl.start = 1'b1;
      ST_ROUT:  out_load = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (pos_re) pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rd_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ta_r   <= addr_a;
        tb_r   <= addr_b;
        tc_r   <= addr_c;
        vidx_r <= in_ch.index_a;
      end
      ST_TP0: p0_r <= pos_rd_r;
      ST_TP1: p1_r <= pos_rd_r;
      ST_TP2: begin
        for (int i = 0; i < 3; i++) begin
          da_r[i] <= {p0_r[i*POS_W+POS_W-1], p0_r[i*POS_W +: POS_W]}
                   - {pos_rd_r[i*POS_W+POS_W-1], pos_rd_r[i*POS_W +: POS_W]};
          db_r[i] <= {pos_rd_r[i*POS_W+POS_W-1], pos_rd_r[i*POS_W +: POS_W]}
                   - {p1_r[i*POS_W+POS_W-1], p1_r[i*POS_W +: POS_W]};
          crs_r[i] <= '0;
        end
        j_r <= '0;
      end
      ST_XPRD: begin
        if (j_r < 3'd6) prd_r <= op_a * op_b;
        if (j_r != 3'd0 && j_r != 3'd7)
          crs_r[cidx] <= op_sub ? crs_r[cidx] - prd_ext : crs_r[cidx] + prd_ext;
        if (j_r != 3'd7) j_r <= j_r + 3'd1;
        corner_r <= '0;
      end
      ST_AWR: corner_r <= corner_r + 2'd1;
      ST_ROUT: begin
        if (out_load) begin
          out_idx_r <= vidx_r;
          for (int i = 0; i < 3; i++) out_n_r[i] <= uz_vout[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_idx_r;
  assign out_ch.normal_x     = out_n_r[0];
  assign out_ch.normal_y     = out_n_r[1];
  assign out_ch.normal_z     = out_n_r[2];

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ROUT))
    else $error("result raised outside the read output step");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    uz_sts.done |-> (state_r == ST_TNRM || state_r == ST_RNRM))
    else $error("unitize finished while nobody waits for it");

  a_accept_uz_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !uz_sts.busy)
    else $error("request accepted while unitize is busy");

endmodule
`default_nettype wire

// ----- dv/tb_vertex_normal_accumulator.sv -----
module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam int VCOUNT = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [IDX_W-1:0] vertex_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
  } normal_t;

  logic clk;
  logic rst_n;
  vna_in_if in_ch ();
  vna_out_if out_ch ();

  vertex_normal_accumulator #(.VERTEX_COUNT(VCOUNT)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  longint pos_mem[VCOUNT][3];
  longint sum_mem[VCOUNT][3];
  bit loaded[VCOUNT];
  normal_t expected_normals[$];
  int errors;
  bit idle_on;
  int stall_cnt;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic unit_vector(input longint v[3], input bit invert, output longint o[3]);
    longint unsigned m[3], mx, len, r, q;
    bit neg[3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    len = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = root_floor(len);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (r >> 1)) / r;
      if (q > 16384) q = 16384;
      o[i] = (neg[i] != invert) ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic accumulate(input int idx, input longint n[3]);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = sum_mem[idx][i] + n[i];
      if (s > 524287) s = 524287;
      if (s < -524288) s = -524288;
      sum_mem[idx][i] = s;
    end
  endtask

  task automatic predict_normal(input logic [1:0] kind, input int ia, input int ib,
                                input int ic, input longint px, input longint py,
                                input longint pz);
    longint a[3], b[3], c[3], n[3];
    normal_t e;
    if (kind == KIND_LOAD) begin
      if (ia >= VCOUNT) return;
      pos_mem[ia] = '{px, py, pz};
      sum_mem[ia] = '{0, 0, 0};
      loaded[ia] = 1'b1;
    end else if (kind == KIND_TRI) begin
      if (ia >= VCOUNT || ib >= VCOUNT || ic >= VCOUNT) return;
      for (int i = 0; i < 3; i++) begin
        a[i] = pos_mem[ia][i] - pos_mem[ic][i];
        b[i] = pos_mem[ic][i] - pos_mem[ib][i];
      end
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      unit_vector(c, 1'b1, n);
      accumulate(ia, n);
      accumulate(ib, n);
      accumulate(ic, n);
    end else if (kind == KIND_READ) begin
      if (ia >= VCOUNT) return;
      unit_vector(sum_mem[ia], 1'b0, n);
      e.vertex_index = IDX_W'(ia);
      e.normal_x = NRM_W'(n[0]);
      e.normal_y = NRM_W'(n[1]);
      e.normal_z = NRM_W'(n[2]);
      expected_normals.push_back(e);
    end
  endtask

  task automatic send_request(input logic [1:0] kind, input int ia, input int ib = 0,
                              input int ic = 0, input int px = 0, input int py = 0,
                              input int pz = 0);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.index_a <= IDX_W'(ia);
    in_ch.index_b <= IDX_W'(ib);
    in_ch.index_c <= IDX_W'(ic);
    in_ch.pos_x <= POS_W'(px);
    in_ch.pos_y <= POS_W'(py);
    in_ch.pos_z <= POS_W'(pz);
    do @(posedge clk); while (!in_ch.ready);
    predict_normal(kind, ia, ib, ic, longint'(16'(px) ^ 16'h8000) - 32768,
                   longint'(16'(py) ^ 16'h8000) - 32768,
                   longint'(16'(pz) ^ 16'h8000) - 32768);
  endtask

  function automatic int loaded_vertex();
    int v;
    do v = $urandom_range(0, 63); while (!loaded[v]);
    return v;
  endfunction

  task automatic load_random(input int idx);
    send_request(KIND_LOAD, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    send_request(KIND_LOAD, 0, 0, 0, 16'sh7FFF, 16'sh8000, 0);
    send_request(KIND_LOAD, 1, 0, 0, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_request(KIND_LOAD, 2, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(KIND_LOAD, 1023, 1023, 1023, 16'shFFFF, 16'sh0100, 16'sh5555);
    send_request(KIND_READ, 0);
    send_request(KIND_TRI, 0, 1, 2);
    send_request(KIND_TRI, 2, 1, 1023);
    send_request(KIND_READ, 0);
    send_request(KIND_READ, 1023);
    send_request(KIND_TRI, 0, 0, 1);
    send_request(KIND_TRI, 1, 1, 1);
    send_request(KIND_READ, 1);
    send_request(KIND_TRI, 1023, 0, 2);
    send_request(KIND_TRI, 2, 2, 2);
    send_request(2'd3, 0, 1, 2, 1, 2, 3);
    send_request(KIND_READ, 2);
    send_request(KIND_LOAD, 1, 0, 0, 16'sh0001, 0, 0);
    send_request(KIND_READ, 1);
  endtask

  task automatic test_saturation();
    send_request(KIND_LOAD, 4, 0, 0, 0, 0, 0);
    send_request(KIND_LOAD, 5, 0, 0, 16'sh7FFF, 0, 0);
    send_request(KIND_LOAD, 6, 0, 0, 0, 16'sh7FFF, 0);
    // drive z sum of vertex 4 well past the limit
    repeat (40) send_request(KIND_TRI, 4, 5, 6);
    send_request(KIND_READ, 4);
    send_request(KIND_READ, 5);
  endtask

  task automatic test_random(input int count);
    int k;
    for (int v = 0; v < 64; v++) load_random(v);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 19);
      if (k < 3) load_random($urandom_range(0, 63));
      else if (k < 12) send_request(KIND_TRI, loaded_vertex(), loaded_vertex(),
                                    loaded_vertex());
      else if (k < 18) send_request(KIND_READ, $urandom_range(0, 1023));
      else if (k == 18) send_request(2'd3, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom);
      else send_request(KIND_LOAD, $urandom_range(0, 1023), $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    end
  endtask

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected result for vertex %0d", out_ch.vertex_index);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (out_ch.vertex_index !== e.vertex_index) begin
          $error("vertex_index: expected %0d, got %0d", e.vertex_index, out_ch.vertex_index);
          errors++;
        end
        if (out_ch.normal_x !== e.normal_x) begin
          $error("normal_x: expected %0d, got %0d", e.normal_x, out_ch.normal_x);
          errors++;
        end
        if (out_ch.normal_y !== e.normal_y) begin
          $error("normal_y: expected %0d, got %0d", e.normal_y, out_ch.normal_y);
          errors++;
        end
        if (out_ch.normal_z !== e.normal_z) begin
          $error("normal_z: expected %0d, got %0d", e.normal_z, out_ch.normal_z);
          errors++;
        end
      end
    end
  end

  // stall the result side in bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ch.ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= (stall_cnt == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(1, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_on = 1'b1;
    stall_cnt = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    out_ch.ready = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.index_a = '0;
    in_ch.index_b = '0;
    in_ch.index_c = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    for (int v = 0; v < VCOUNT; v++) begin
      sum_mem[v] = '{0, 0, 0};
      pos_mem[v] = '{0, 0, 0};
      loaded[v] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_saturation();
    test_random(850);
    idle_on = 1'b0;
    test_random(150);
    in_ch.valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
